### src/mrf_pkg.sv
package mrf_pkg;

  // Field widths
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CrcW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Write frames carry at most this many data bytes
  localparam logic [ByteW-1:0] MaxWriteBytes = 8'd246;

  // CRC-16/MODBUS: reflected polynomial, all-ones preset
  localparam logic [CrcW-1:0] CrcPoly = 16'hA001;
  localparam logic [CrcW-1:0] CrcInit = 16'hFFFF;

  // Register reset values
  localparam logic [ByteW-1:0] SlaveRst   = 8'h09;
  localparam logic [ByteW-1:0] WrCodeRst  = 8'h10;
  localparam logic [ByteW-1:0] RdCodeRst  = 8'h04;
  localparam logic [CrcW-1:0]  WrBaseRst  = 16'd1000;
  localparam logic [CrcW-1:0]  RdBaseRst  = 16'd2000;

  // Register indexes on the config port
  typedef enum logic [CfgIdxW-1:0] {
    REG_SLAVE   = 3'd0,
    REG_WR_CODE = 3'd1,
    REG_RD_CODE = 3'd2,
    REG_WR_BASE = 3'd3,
    REG_RD_BASE = 3'd4
  } cfg_reg_t;

  // Request selector codes
  typedef enum logic [1:0] {
    FUNC_READ    = 2'd0,
    FUNC_WR_HDR  = 2'd1,
    FUNC_WR_DATA = 2'd2
  } func_t;

  // Current register settings
  typedef struct packed {
    logic [ByteW-1:0] slave;
    logic [ByteW-1:0] wr_code;
    logic [ByteW-1:0] rd_code;
    logic [CrcW-1:0]  wr_base;
    logic [CrcW-1:0]  rd_base;
  } cfg_t;

  // One byte of CRC update, LSB first
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc_in,
                                               input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/mrf_in_if.sv
interface mrf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] reg_index;
  logic [7:0] byte_count;
  logic [7:0] data_byte;

  modport source (output valid, func, reg_index, byte_count, data_byte, input ready);
  modport sink   (input valid, func, reg_index, byte_count, data_byte, output ready);
endinterface

### src/mrf_out_if.sv
interface mrf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

### src/mrf_cfg_regs.sv
module mrf_cfg_regs (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [mrf_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mrf_pkg::CfgDataW-1:0] cfg_wdata,
  output mrf_pkg::cfg_t          cfg
);
  import mrf_pkg::*;

  cfg_t cfg_r;

  assign cfg = cfg_r;

  // Register file; writes outside the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave   <= SlaveRst;
      cfg_r.wr_code <= WrCodeRst;
      cfg_r.rd_code <= RdCodeRst;
      cfg_r.wr_base <= WrBaseRst;
      cfg_r.rd_base <= RdBaseRst;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SLAVE:   cfg_r.slave   <= cfg_wdata[ByteW-1:0];
        REG_WR_CODE: cfg_r.wr_code <= cfg_wdata[ByteW-1:0];
        REG_RD_CODE: cfg_r.rd_code <= cfg_wdata[ByteW-1:0];
        REG_WR_BASE: cfg_r.wr_base <= cfg_wdata;
        REG_RD_BASE: cfg_r.rd_base <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

### src/modbus_rtu_request_framer.sv
// Channel   Dir  Beat contents
// in_ch     in   func, reg_index, byte_count, data_byte (one request)
// out_ch    out  frame_byte, frame_end (one frame byte)
// cfg_*     in   cfg_we, cfg_index, cfg_wdata (register write, no wait)
//
// A request occupies the byte sequencer while it makes its frame bytes:
// 8 for a read, 7 for a write header (9 when empty), 1 or 3 for a data byte.
// Requests that make no bytes do not occupy it. The next request is taken in
// the cycle its predecessor's last byte moves into the output register.
// The CRC takes one body byte per cycle as bytes leave an unstalled sequencer.
// Reset is synchronous; it empties the sequencer and output register and
// restores the registers. A stalled output holds its beat and stalls input while busy.
module modbus_rtu_request_framer (
  input  logic                          clk,
  input  logic                          rst_n,
  mrf_in_if.sink                        in_ch,
  mrf_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mrf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [mrf_pkg::CfgDataW-1:0]  cfg_wdata
);
  import mrf_pkg::*;

  typedef enum logic [1:0] {
    KIND_READ,
    KIND_WR_HDR,
    KIND_WR_DATA
  } kind_t;

  // Byte positions of the CRC within each kind of item, and of a write header's last byte
  localparam logic [3:0] ReadCrcPos  = 4'd6;
  localparam logic [3:0] WrHdrCrcPos = 4'd7;
  localparam logic [3:0] WrHdrLast   = 4'd6;
  localparam logic [3:0] DataCrcPos  = 4'd1;

  cfg_t cfg;

  logic             busy_r;
  logic [3:0]       pos_r;
  logic [3:0]       last_pos_r;
  logic [3:0]       crc_pos_r;
  kind_t            kind_r;
  logic [ByteW-1:0] lo_r;
  logic [ByteW-1:0] cnt_r;
  logic [ByteW-1:0] dat_r;
  logic [CrcW-1:0]  crc_r;
  logic [ByteW-1:0] rem_r;
  logic             out_valid_r;
  logic [ByteW-1:0] out_byte_r;
  logic             out_end_r;

  logic             accept;
  logic             adv;
  logic             load;
  logic             last_load;
  logic [ByteW-1:0] len;
  logic [ByteW-1:0] rd_lo;
  logic [ByteW-1:0] wr_lo;
  logic [ByteW-1:0] rem_dec;
  logic [3:0]       crc_hi_pos;
  logic [ByteW-1:0] hdr_byte;
  logic [ByteW-1:0] cur_byte;
  logic             cur_end;

  mrf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Handshake
  assign accept    = in_ch.valid & in_ch.ready;
  assign adv       = !out_valid_r | out_ch.ready;
  assign load      = busy_r & adv;
  assign last_load = load & (pos_r == last_pos_r);
  assign in_ch.ready = !busy_r | last_load;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = out_byte_r;
  assign out_ch.frame_end  = out_end_r;

  // Request decode
  assign len     = (in_ch.byte_count > MaxWriteBytes) ? MaxWriteBytes : in_ch.byte_count;
  assign rd_lo   = cfg.rd_base[ByteW-1:0] + in_ch.reg_index;
  assign wr_lo   = cfg.wr_base[ByteW-1:0] + in_ch.reg_index;
  assign rem_dec = rem_r - 8'd1;

  // Header byte at the current position
  always_comb begin
    hdr_byte = '0;
    unique case (kind_r)
      KIND_READ: begin
        unique case (pos_r)
          4'd0:    hdr_byte = cfg.slave;
          4'd1:    hdr_byte = cfg.rd_code;
          4'd2:    hdr_byte = cfg.rd_base[CrcW-1:ByteW];
          4'd3:    hdr_byte = lo_r;
          4'd5:    hdr_byte = {1'b0, cnt_r[ByteW-1:1]};
          default: hdr_byte = '0;
        endcase
      end
      KIND_WR_HDR: begin
        unique case (pos_r)
          4'd0:    hdr_byte = cfg.slave;
          4'd1:    hdr_byte = cfg.wr_code;
          4'd2:    hdr_byte = cfg.wr_base[CrcW-1:ByteW];
          4'd3:    hdr_byte = lo_r;
          4'd5:    hdr_byte = {1'b0, cnt_r[ByteW-1:1]};
          4'd6:    hdr_byte = cnt_r;
          default: hdr_byte = '0;
        endcase
      end
      KIND_WR_DATA: hdr_byte = dat_r;
      default:      hdr_byte = '0;
    endcase
  end

  // CRC bytes follow the body, low byte first
  assign crc_hi_pos = crc_pos_r + 4'd1;
  assign cur_end    = (pos_r == crc_hi_pos);

  always_comb begin
    priority if (pos_r == crc_pos_r) begin
      cur_byte = crc_r[ByteW-1:0];
    end else if (cur_end) begin
      cur_byte = crc_r[CrcW-1:ByteW];
    end else begin
      cur_byte = hdr_byte;
    end
  end

  // Control state, running CRC and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= '0;
      last_pos_r  <= '0;
      crc_pos_r   <= '0;
      kind_r      <= KIND_READ;
      crc_r       <= CrcInit;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // sequencer hands one byte to the output register
      if (load) begin
        pos_r <= pos_r + 4'd1;
        if (pos_r < crc_pos_r) begin
          crc_r <= crc_byte(crc_r, cur_byte);
        end
      end
      if (last_load) begin
        busy_r <= 1'b0;
      end

      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // new request
      if (accept) begin
        unique case (func_t'(in_ch.func))
          FUNC_READ: begin
            busy_r     <= 1'b1;
            pos_r      <= '0;
            kind_r     <= KIND_READ;
            crc_pos_r  <= ReadCrcPos;
            last_pos_r <= ReadCrcPos + 4'd1;
            crc_r      <= CrcInit;
            rem_r      <= '0;
          end
          FUNC_WR_HDR: begin
            busy_r     <= 1'b1;
            pos_r      <= '0;
            kind_r     <= KIND_WR_HDR;
            crc_pos_r  <= WrHdrCrcPos;
            last_pos_r <= (len == '0) ? WrHdrCrcPos + 4'd1 : WrHdrLast;
            crc_r      <= CrcInit;
            rem_r      <= len;
          end
          FUNC_WR_DATA: begin
            // stray data byte outside a write frame is dropped
            if (rem_r != '0) begin
              busy_r     <= 1'b1;
              pos_r      <= '0;
              kind_r     <= KIND_WR_DATA;
              crc_pos_r  <= DataCrcPos;
              last_pos_r <= (rem_dec == '0) ? DataCrcPos + 4'd1 : 4'd0;
              rem_r      <= rem_dec;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Item payload and output data
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_end_r  <= cur_end;
    end
    if (accept) begin
      lo_r  <= (func_t'(in_ch.func) == FUNC_READ) ? rd_lo : wr_lo;
      cnt_r <= (func_t'(in_ch.func) == FUNC_READ) ? in_ch.byte_count : len;
      dat_r <= in_ch.data_byte;
    end
  end

endmodule
